FILE: rtl/push_button_dim_value_encoder_core_assert.svh
// Assertion macros for the checker file of the push-button value encoder
`ifndef PUSH_BUTTON_DIM_VALUE_ENCODER_CORE_ASSERT_SVH
`define PUSH_BUTTON_DIM_VALUE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PBDVE_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PBDVE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/pbdve_pkg.sv
// Types and constants of the push-button value encoder
`default_nettype none

package pbdve_pkg;

	// Input action codes
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_PIN    = 2'd1,
		ACT_REINIT = 2'd2
	} action_t;

	// Edge modes
	localparam logic [1:0] EDGE_PRESS   = 2'd0;
	localparam logic [1:0] EDGE_RELEASE = 2'd1;
	localparam logic [1:0] EDGE_NONE    = 2'd2;
	localparam logic [1:0] EDGE_BOTH    = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DISABLED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_VALUE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS  = 3'd6;

	// Configuration reset values
	localparam logic [3:0]  STEP_SIZE_RST   = 4'd1;
	localparam logic [15:0] LONG_TICKS_RST  = 16'd500;
	localparam logic [15:0] REPEAT_TICKS_RST = 16'd100;

	// Ramp limits
	localparam logic signed [9:0] RAMP_FULL = 10'sd255;
	localparam logic signed [9:0] RAMP_ZERO = 10'sd0;
	localparam logic signed [9:0] RAMP_MAX  = 10'sd511;
	localparam logic signed [9:0] RAMP_MIN  = -10'sd512;
	localparam logic [7:0]        FULL_VALUE = 8'd255;
	localparam logic signed [4:0] STEP_RST  = 5'sd1;

	// Shared configuration
	typedef struct packed {
		logic [1:0]  edge_mode;
		logic        ramp_disabled;
		logic [7:0]  press_value;
		logic [7:0]  release_value;
		logic [3:0]  step_size;
		logic [15:0] long_press_ticks;
		logic [15:0] repeat_ticks;
	} cfg_t;

	// Per-channel state except the timer count
	typedef struct packed {
		logic signed [9:0] ramp_value;
		logic signed [4:0] ramp_step;
		logic              first_expiry;
		logic              timer_running;
		logic [7:0]        last_sent;
	} chan_state_t;

	// One result item without its channel
	typedef struct packed {
		logic       send_valid;
		logic [7:0] object_value;
		logic       store_request;
		logic [7:0] store_value;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/push_button_dim_value_encoder_core.sv
// Top level of the push-button value encoder with long-press ramp
`default_nettype none

// Push-button value encoder for up to CHANNELS buttons that share one
// configuration. Each item (tick, pin change or reinit) gives exactly one
// result. Items are taken one per clock cycle back to back while results
// drain; a result passes the input register, then the result register. The
// per-channel state sits in flip-flops and is read, updated and written
// back in the cycle the item leaves the input register, so items
// for the same channel in consecutive cycles see each other's updates. A
// stalled result register holds the input register, and ready falls only
// when both are full. Configuration writes take effect on the next edge and
// are meant to happen while no item is in flight.
module push_button_dim_value_encoder_core #(
	parameter int CHANNELS   = 8,
	parameter int TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pbdve_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pbdve_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [2:0]                          chan,
	input  logic [1:0]                          action,
	input  logic                                level,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [2:0]                          chan_out,
	output logic                                send_valid,
	output logic [7:0]                          object_value,
	output logic                                store_request,
	output logic [7:0]                          store_value
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	pbdve_pkg::cfg_t        cfg_q;
	pbdve_pkg::chan_state_t st_q [CHANNELS];
	logic [TIMER_BITS-1:0]  left_q [CHANNELS];

	logic                   valid_s1;
	logic [2:0]             chan_s1;
	pbdve_pkg::action_t     action_s1;
	logic                   level_s1;

	logic                   result_valid_q;
	logic [2:0]             chan_out_q;
	pbdve_pkg::result_t     res_q;

	logic                   adv;
	logic                   chan_hit;
	logic [5:0]             chan_ext;
	logic [CH_W-1:0]        idx;
	pbdve_pkg::chan_state_t st_d;
	logic [TIMER_BITS-1:0]  left_d;
	pbdve_pkg::result_t     res_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_mode        <= pbdve_pkg::EDGE_PRESS;
			cfg_q.ramp_disabled    <= 1'b0;
			cfg_q.press_value      <= 8'd0;
			cfg_q.release_value    <= 8'd0;
			cfg_q.step_size        <= pbdve_pkg::STEP_SIZE_RST;
			cfg_q.long_press_ticks <= pbdve_pkg::LONG_TICKS_RST;
			cfg_q.repeat_ticks     <= pbdve_pkg::REPEAT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbdve_pkg::REG_EDGE_MODE:     cfg_q.edge_mode        <= cfg_data[1:0];
				pbdve_pkg::REG_RAMP_DISABLED: cfg_q.ramp_disabled    <= cfg_data[0];
				pbdve_pkg::REG_PRESS_VALUE:   cfg_q.press_value      <= cfg_data[7:0];
				pbdve_pkg::REG_RELEASE_VALUE: cfg_q.release_value    <= cfg_data[7:0];
				pbdve_pkg::REG_STEP_SIZE:     cfg_q.step_size        <= cfg_data[3:0];
				pbdve_pkg::REG_LONG_TICKS:    cfg_q.long_press_ticks <= cfg_data;
				pbdve_pkg::REG_REPEAT_TICKS:  cfg_q.repeat_ticks     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: advance when the result register is free or drains
	assign adv        = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			chan_s1   <= chan;
			action_s1 <= pbdve_pkg::action_t'(action);
			level_s1  <= level;
		end
	end

	// Channel select
	assign chan_ext = {3'b000, chan_s1};
	assign chan_hit = {29'b0, chan_s1} < 32'(CHANNELS);
	assign idx      = chan_ext[CH_W-1:0];

	pbdve_chan_calc #(
		.TIMER_BITS (TIMER_BITS)
	) u_calc (
		.cfg    (cfg_q),
		.action (action_s1),
		.level  (level_s1),
		.st     (st_q[idx]),
		.left   (left_q[idx]),
		.st_d   (st_d),
		.left_d (left_d),
		.res    (res_d)
	);

	// Write back the channel state on transfer to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				st_q[i].ramp_value    <= pbdve_pkg::RAMP_ZERO;
				st_q[i].ramp_step     <= pbdve_pkg::STEP_RST;
				st_q[i].first_expiry  <= 1'b0;
				st_q[i].timer_running <= 1'b0;
				st_q[i].last_sent     <= 8'd0;
				left_q[i]             <= '0;
			end
		end else if (adv && chan_hit) begin
			st_q[idx]   <= st_d;
			left_q[idx] <= left_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_out_q <= chan_s1;
			res_q      <= chan_hit ? res_d : '0;
		end
	end

	assign result_valid  = result_valid_q;
	assign chan_out      = chan_out_q;
	assign send_valid    = res_q.send_valid;
	assign object_value  = res_q.object_value;
	assign store_request = res_q.store_request;
	assign store_value   = res_q.store_value;

endmodule

`default_nettype wire

FILE: rtl/pbdve_chan_calc.sv
// Next-state and result logic for one channel and one item
`default_nettype none

module pbdve_chan_calc #(
	parameter int TIMER_BITS = 16
) (
	input  pbdve_pkg::cfg_t        cfg,
	input  pbdve_pkg::action_t     action,
	input  logic                   level,
	input  pbdve_pkg::chan_state_t st,
	input  logic [TIMER_BITS-1:0]  left,
	output pbdve_pkg::chan_state_t st_d,
	output logic [TIMER_BITS-1:0]  left_d,
	output pbdve_pkg::result_t     res
);

	logic                  ramping;
	logic signed [4:0]     step_eff;
	logic signed [10:0]    sum;
	logic signed [9:0]     ramp_sat;
	logic [31:0]           long_ext;
	logic [31:0]           rep_ext;
	logic [TIMER_BITS-1:0] long_sat;
	logic [TIMER_BITS-1:0] rep_sat;
	logic                  expire;

	// Clamp the timer lengths to the counter width
	always_comb begin
		long_ext = {16'b0, cfg.long_press_ticks};
		rep_ext  = {16'b0, cfg.repeat_ticks};
		if ((long_ext >> TIMER_BITS) != 32'd0) begin
			long_sat = '1;
		end else begin
			long_sat = long_ext[TIMER_BITS-1:0];
		end
		if ((rep_ext >> TIMER_BITS) != 32'd0) begin
			rep_sat = '1;
		end else begin
			rep_sat = rep_ext[TIMER_BITS-1:0];
		end
	end

	// Ramp step and saturating sum
	always_comb begin
		step_eff = st.first_expiry ? -st.ramp_step : st.ramp_step;
		sum = {st.ramp_value[9], st.ramp_value} + {{6{step_eff[4]}}, step_eff};
		if (sum[10] != sum[9]) begin
			ramp_sat = sum[10] ? pbdve_pkg::RAMP_MIN : pbdve_pkg::RAMP_MAX;
		end else begin
			ramp_sat = sum[9:0];
		end
	end

	assign ramping = (cfg.edge_mode != pbdve_pkg::EDGE_BOTH) && !cfg.ramp_disabled;
	assign expire  = left <= {{(TIMER_BITS-1){1'b0}}, 1'b1};

	// Decode the action and update the channel
	always_comb begin
		st_d   = st;
		left_d = left;
		res    = '0;
		case (action)
			pbdve_pkg::ACT_TICK: begin
				if (st.timer_running) begin
					if (expire) begin
						st_d.timer_running = 1'b0;
						left_d             = '0;
						st_d.first_expiry  = 1'b0;
						st_d.ramp_step     = step_eff;
						st_d.ramp_value    = ramp_sat;
						res.send_valid     = 1'b1;
						if (ramp_sat >= pbdve_pkg::RAMP_FULL) begin
							res.object_value = pbdve_pkg::FULL_VALUE;
						end else if (ramp_sat <= pbdve_pkg::RAMP_ZERO) begin
							res.object_value = 8'd0;
						end else begin
							res.object_value   = ramp_sat[7:0];
							st_d.timer_running = 1'b1;
							left_d             = rep_sat;
						end
					end else begin
						left_d = left - {{(TIMER_BITS-1){1'b0}}, 1'b1};
					end
				end
			end
			pbdve_pkg::ACT_PIN: begin
				// Release with ramping on stops the ramp and asks to store the last value
				if (!level && ramping) begin
					st_d.timer_running = 1'b0;
					left_d             = '0;
					res.store_request  = 1'b1;
					res.store_value    = st.last_sent;
				end
				if (level && (cfg.edge_mode == pbdve_pkg::EDGE_PRESS ||
						cfg.edge_mode == pbdve_pkg::EDGE_BOTH)) begin
					res.send_valid   = 1'b1;
					res.object_value = cfg.press_value;
				end else if (!level && (cfg.edge_mode == pbdve_pkg::EDGE_RELEASE ||
						cfg.edge_mode == pbdve_pkg::EDGE_BOTH)) begin
					res.send_valid   = 1'b1;
					res.object_value = (cfg.edge_mode == pbdve_pkg::EDGE_RELEASE) ?
						cfg.press_value : cfg.release_value;
				end
				// Press with ramping on arms the long-press timer
				if (level && ramping) begin
					st_d.timer_running = 1'b1;
					left_d             = long_sat;
					st_d.first_expiry  = 1'b1;
				end
			end
			pbdve_pkg::ACT_REINIT: begin
				st_d.ramp_value = {2'b00, cfg.press_value};
				st_d.ramp_step  = {1'b0, cfg.step_size};
				st_d.last_sent  = 8'd0;
			end
			default: begin
			end
		endcase
		if (res.send_valid) begin
			st_d.last_sent = res.object_value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pbdve_checker.sv
// Port checker for the push-button value encoder and its bind
`default_nettype none

`include "push_button_dim_value_encoder_core_assert.svh"

module pbdve_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic       send_valid,
	input logic [7:0] object_value,
	input logic       store_request,
	input logic [7:0] store_value
);

	// Hold a stalled result
	`PBDVE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
	`PBDVE_ASSERT_NEXT(a_value_hold, clk, arst_n, result_valid && !result_ready, $stable(object_value), "object value changed while stalled")

	// Unused value fields read as zero
	`PBDVE_ASSERT_NOW(a_value_zero, clk, arst_n, result_valid && !send_valid, object_value == 8'd0, "object value without send")
	`PBDVE_ASSERT_NOW(a_store_zero, clk, arst_n, result_valid && !store_request, store_value == 8'd0, "store value without request")

endmodule

bind push_button_dim_value_encoder_core pbdve_checker u_pbdve_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.send_valid    (send_valid),
	.object_value  (object_value),
	.store_request (store_request),
	.store_value   (store_value)
);

`default_nettype wire

FILE: dv/tb.sv
// Testbench for the push-button value encoder core: random stimulus checked against a predictor
`timescale 1ns / 100ps

module tb;

	// Action code outside the defined set, and a register index with no register
	localparam logic [1:0]                      ACT_SPARE = 2'd3;
	localparam logic [pbdve_pkg::CFG_IDX_W-1:0] REG_NONE  = 3'd7;

	localparam int ITEM_COUNT     = 1500;
	localparam int SQUEEZE_AFTER  = 300;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int PRINT_CAP      = 100;

	// One result frame: channel plus value fields
	typedef struct packed {
		logic [2:0]         chan;
		pbdve_pkg::result_t body;
	} dimmer_frame_t;

	// Per-channel predictor and queue of frames the block still owes
	class dimmer_ledger;
		pbdve_pkg::cfg_t   shared;
		logic signed [9:0] ramp_level [8];
		logic signed [4:0] ramp_dir   [8];
		logic              first_hit  [8];
		logic              armed      [8];
		logic [15:0]       ticks_left [8];
		logic [7:0]        last_value [8];
		dimmer_frame_t     owed_frames [$];
		int mismatches, matched, effective, steps, full_stops, zero_stops, stores;

		function void power_up();
			shared = '{pbdve_pkg::EDGE_PRESS, 1'b0, 8'd0, 8'd0, pbdve_pkg::STEP_SIZE_RST,
				pbdve_pkg::LONG_TICKS_RST, pbdve_pkg::REPEAT_TICKS_RST};
			for (int c = 0; c < 8; c++) begin
				ramp_level[c] = {2'b00, shared.press_value};
				ramp_dir[c]   = pbdve_pkg::STEP_RST;
				first_hit[c]  = 1'b0;
				armed[c]      = 1'b0;
				ticks_left[c] = '0;
				last_value[c] = '0;
			end
		endfunction

		function void set_reg(logic [pbdve_pkg::CFG_IDX_W-1:0] idx,
				logic [pbdve_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				pbdve_pkg::REG_EDGE_MODE:     shared.edge_mode        = data[1:0];
				pbdve_pkg::REG_RAMP_DISABLED: shared.ramp_disabled    = data[0];
				pbdve_pkg::REG_PRESS_VALUE:   shared.press_value      = data[7:0];
				pbdve_pkg::REG_RELEASE_VALUE: shared.release_value    = data[7:0];
				pbdve_pkg::REG_STEP_SIZE:     shared.step_size        = data[3:0];
				pbdve_pkg::REG_LONG_TICKS:    shared.long_press_ticks = data;
				pbdve_pkg::REG_REPEAT_TICKS:  shared.repeat_ticks     = data;
				default: ;
			endcase
		endfunction

		// Work out the frame for one transfer and advance the channel state
		function void log_item(logic [2:0] c, logic [1:0] a, logic l);
			dimmer_frame_t f;
			logic          ramping;
			int            v;
			f = '0;
			f.chan = c;
			ramping = (shared.edge_mode != pbdve_pkg::EDGE_BOTH) && !shared.ramp_disabled;
			case (a)
				pbdve_pkg::ACT_TICK: begin
					if (armed[c]) begin
						effective++;
						if (ticks_left[c] <= 16'd1) begin
							armed[c] = 1'b0;
							ticks_left[c] = '0;
							// direction flips only on the first expiry of a press
							if (first_hit[c]) begin
								first_hit[c] = 1'b0;
								ramp_dir[c] = -ramp_dir[c];
							end
							v = int'(ramp_level[c]) + int'(ramp_dir[c]);
							if (v > int'(pbdve_pkg::RAMP_MAX)) v = int'(pbdve_pkg::RAMP_MAX);
							if (v < int'(pbdve_pkg::RAMP_MIN)) v = int'(pbdve_pkg::RAMP_MIN);
							ramp_level[c] = v[9:0];
							f.body.send_valid = 1'b1;
							steps++;
							if (v >= int'(pbdve_pkg::RAMP_FULL)) begin
								f.body.object_value = pbdve_pkg::FULL_VALUE;
								full_stops++;
							end else if (v <= int'(pbdve_pkg::RAMP_ZERO)) begin
								f.body.object_value = 8'd0;
								zero_stops++;
							end else begin
								f.body.object_value = v[7:0];
								armed[c] = 1'b1;
								ticks_left[c] = shared.repeat_ticks;
							end
						end else begin
							ticks_left[c] = ticks_left[c] - 16'd1;
						end
					end
				end
				pbdve_pkg::ACT_PIN: begin
					effective++;
					// release stops the ramp and asks to keep the last value
					if (!l && ramping) begin
						armed[c] = 1'b0;
						ticks_left[c] = '0;
						f.body.store_request = 1'b1;
						f.body.store_value = last_value[c];
						stores++;
					end
					if (l && (shared.edge_mode == pbdve_pkg::EDGE_PRESS ||
							shared.edge_mode == pbdve_pkg::EDGE_BOTH)) begin
						f.body.send_valid = 1'b1;
						f.body.object_value = shared.press_value;
					end else if (!l && (shared.edge_mode == pbdve_pkg::EDGE_RELEASE ||
							shared.edge_mode == pbdve_pkg::EDGE_BOTH)) begin
						f.body.send_valid = 1'b1;
						f.body.object_value = (shared.edge_mode == pbdve_pkg::EDGE_RELEASE) ?
							shared.press_value : shared.release_value;
					end
					if (l && ramping) begin
						armed[c] = 1'b1;
						ticks_left[c] = shared.long_press_ticks;
						first_hit[c] = 1'b1;
					end
				end
				pbdve_pkg::ACT_REINIT: begin
					effective++;
					ramp_level[c] = {2'b00, shared.press_value};
					ramp_dir[c] = {1'b0, shared.step_size};
					last_value[c] = '0;
				end
				default: ;
			endcase
			if (f.body.send_valid) last_value[c] = f.body.object_value;
			owed_frames.push_back(f);
		endfunction

		task note_mismatch(string what, logic [7:0] got, logic [7:0] want);
			if (mismatches < PRINT_CAP)
				$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
			mismatches++;
		endtask

		// Compare one delivered frame with the oldest owed one
		task match_result(logic [2:0] c, pbdve_pkg::result_t got);
			dimmer_frame_t want;
			if (owed_frames.size() == 0) begin
				note_mismatch("result with nothing owed, channel", 8'(c), 8'd0);
				return;
			end
			want = owed_frames.pop_front();
			matched++;
			if (c !== want.chan) note_mismatch("chan_out", 8'(c), 8'(want.chan));
			if (got.send_valid !== want.body.send_valid)
				note_mismatch("send_valid", 8'(got.send_valid), 8'(want.body.send_valid));
			if (got.object_value !== want.body.object_value)
				note_mismatch("object_value", got.object_value, want.body.object_value);
			if (got.store_request !== want.body.store_request)
				note_mismatch("store_request", 8'(got.store_request),
					8'(want.body.store_request));
			if (got.store_value !== want.body.store_value)
				note_mismatch("store_value", got.store_value, want.body.store_value);
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [pbdve_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pbdve_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             item_valid;
	logic                             item_ready;
	logic [2:0]                       chan;
	logic [1:0]                       action;
	logic                             level;
	logic                             result_valid;
	logic                             result_ready;
	logic [2:0]                       chan_out;
	logic                             send_valid;
	logic [7:0]                       object_value;
	logic                             store_request;
	logic [7:0]                       store_value;

	dimmer_ledger ledger = new;
	int transfers;
	int settings_used;
	int holdoffs;
	bit steady;

	push_button_dim_value_encoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.chan          (chan),
		.action        (action),
		.level         (level),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.chan_out      (chan_out),
		.send_valid    (send_valid),
		.object_value  (object_value),
		.store_request (store_request),
		.store_value   (store_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short pauses, now and then a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	// Keep the register bits, fill the unused data bits with noise
	function automatic logic [15:0] noisy(logic [15:0] v, logic [15:0] keep);
		return (16'($urandom) & ~keep) | (v & keep);
	endfunction

	task automatic write_reg(input logic [pbdve_pkg::CFG_IDX_W-1:0] idx,
			input logic [pbdve_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		ledger.set_reg(idx, val);
	endtask

	task automatic apply_setting(input pbdve_pkg::cfg_t s);
		write_reg(pbdve_pkg::REG_EDGE_MODE, noisy(16'(s.edge_mode), 16'h0003));
		write_reg(pbdve_pkg::REG_RAMP_DISABLED, noisy(16'(s.ramp_disabled), 16'h0001));
		write_reg(pbdve_pkg::REG_PRESS_VALUE, noisy(16'(s.press_value), 16'h00FF));
		write_reg(pbdve_pkg::REG_RELEASE_VALUE, noisy(16'(s.release_value), 16'h00FF));
		write_reg(pbdve_pkg::REG_STEP_SIZE, noisy(16'(s.step_size), 16'h000F));
		write_reg(pbdve_pkg::REG_LONG_TICKS, s.long_press_ticks);
		write_reg(pbdve_pkg::REG_REPEAT_TICKS, s.repeat_ticks);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offer one item, hold it until the transfer, then maybe pause
	task automatic push_item(input logic [2:0] c, input logic [1:0] a, input logic l);
		int pause;
		item_valid <= 1'b1;
		chan <= c;
		action <= a;
		level <= l;
		do @(posedge clk); while (!item_ready);
		ledger.log_item(c, a, l);
		transfers++;
		pause = steady ? 0 : pick_pause();
		if (pause > 0) begin
			item_valid <= 1'b0;
			chan <= 3'($urandom);
			action <= 2'($urandom);
			level <= 1'($urandom);
			repeat (pause) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed frame is back
	task automatic settle();
		item_valid <= 1'b0;
		while (ledger.owed_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic pbdve_pkg::cfg_t pick_setting(int p);
		pbdve_pkg::cfg_t s;
		case (p)
			0: s = '{pbdve_pkg::EDGE_RELEASE, 1'b0, 8'd255, 8'd0, 4'd15, 16'd1, 16'd1};
			1: s = '{pbdve_pkg::EDGE_NONE, 1'b0, 8'd0, 8'd255, 4'd0, 16'd3, 16'd2};
			2: s = '{pbdve_pkg::EDGE_BOTH, 1'b0, 8'd128, 8'd255, 4'd7, 16'd2, 16'hFFFF};
			3: s = '{pbdve_pkg::EDGE_PRESS, 1'b1, 8'd77, 8'd1, 4'd15, 16'hFFFF, 16'd1};
			4: s = '{pbdve_pkg::EDGE_PRESS, 1'b0, 8'd128, 8'd200, 4'd15, 16'd1, 16'd2};
			default: begin
				s.edge_mode = 2'($urandom_range(0, 3));
				s.ramp_disabled = ($urandom_range(0, 4) == 0);
				s.press_value = 8'($urandom);
				s.release_value = 8'($urandom);
				s.step_size = 4'($urandom);
				s.long_press_ticks = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 6));
				s.repeat_ticks = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 4));
			end
		endcase
		return s;
	endfunction

	// Mostly press, tick run, release on a couple of busy channels; the rest noise
	task automatic play_phase(input int budget);
		int         stop_at, k, r;
		logic [2:0] f0, f1, c;
		stop_at = transfers + budget;
		f0 = 3'($urandom);
		f1 = 3'($urandom);
		while (transfers < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				c = ($urandom_range(0, 4) == 0) ? 3'($urandom) : ($urandom_range(0, 1) ? f0 : f1);
				push_item(c, pbdve_pkg::ACT_PIN, 1'b1);
				k = $urandom_range(0, 40);
				repeat (k) begin
					if ($urandom_range(0, 9) == 0)
						push_item(3'($urandom), 2'($urandom), 1'($urandom));
					else
						push_item(c, pbdve_pkg::ACT_TICK, 1'($urandom));
				end
				if ($urandom_range(0, 9) != 0) push_item(c, pbdve_pkg::ACT_PIN, 1'b0);
			end else if (r < 85) begin
				push_item(3'($urandom), pbdve_pkg::ACT_REINIT, 1'($urandom));
			end else if (r < 90) begin
				push_item(3'($urandom), ACT_SPARE, 1'($urandom));
			end else begin
				push_item(3'($urandom), 2'($urandom), 1'($urandom));
			end
		end
	endtask

	// Result side: random ready, one long hold-off while the sender is busy
	initial begin
		int run_left, stall_left;
		bit squeezed;
		run_left = 0;
		stall_left = 0;
		squeezed = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				ledger.match_result(chan_out,
					{send_valid, object_value, store_request, store_value});
			if (!squeezed && ledger.matched >= SQUEEZE_AFTER && item_valid) begin
				squeezed = 1'b1;
				stall_left = SQUEEZE_CYCLES;
				run_left = 0;
				holdoffs++;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				result_ready <= 1'b1;
			end else begin
				run_left = $urandom_range(1, 40);
				stall_left = pick_pause();
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int p;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_valid <= 1'b0;
		chan <= '0;
		action <= pbdve_pkg::ACT_TICK;
		level <= 1'b0;
		steady = 1'b0;
		ledger.power_up();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero-length long press, full and zero stops, restart, spare action
		write_reg(REG_NONE, 16'($urandom));
		apply_setting('{pbdve_pkg::EDGE_PRESS, 1'b0, 8'd250, 8'd5, 4'd15, 16'd0, 16'd1});
		push_item(3'd0, pbdve_pkg::ACT_REINIT, 1'b0);
		push_item(3'd0, pbdve_pkg::ACT_PIN, 1'b1);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b0);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b1);
		push_item(3'd0, pbdve_pkg::ACT_PIN, 1'b1);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b0);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b0);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b1);
		push_item(3'd0, pbdve_pkg::ACT_TICK, 1'b0);
		push_item(3'd0, pbdve_pkg::ACT_PIN, 1'b0);
		push_item(3'd1, pbdve_pkg::ACT_PIN, 1'b1);
		push_item(3'd1, pbdve_pkg::ACT_TICK, 1'b0);
		push_item(3'd7, ACT_SPARE, 1'b1);
		push_item(3'd7, pbdve_pkg::ACT_REINIT, 1'b1);
		push_item(3'd7, pbdve_pkg::ACT_PIN, 1'b1);
		push_item(3'd7, pbdve_pkg::ACT_PIN, 1'b0);
		push_item(3'd3, pbdve_pkg::ACT_PIN, 1'b0);
		push_item(3'd2, pbdve_pkg::ACT_PIN, 1'b1);
		push_item(3'd7, pbdve_pkg::ACT_TICK, 1'b1);

		// Random phases, each under its own setting; timers keep running across writes
		p = 0;
		while (transfers < ITEM_COUNT) begin
			settle();
			apply_setting(pick_setting(p));
			steady = ($urandom_range(0, 3) == 0);
			play_phase(200);
			p++;
		end
		settle();
		repeat (10) @(posedge clk);
		if (ledger.owed_frames.size() != 0)
			ledger.note_mismatch("frames never delivered", 8'(ledger.owed_frames.size()), 8'd0);

		$display("%0d transfers (%0d with effect) over %0d settings, %0d results compared",
			transfers, ledger.effective, settings_used, ledger.matched);
		$display("%0d ramp steps, %0d stopped at full, %0d at zero, %0d store requests, %0d hold-offs",
			ledger.steps, ledger.full_stops, ledger.zero_stops, ledger.stores, holdoffs);
		if (ledger.mismatches == 0) begin
			$display("push_button_dim_value_encoder_core regression: pass");
		end else begin
			$display("push_button_dim_value_encoder_core regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("push_button_dim_value_encoder_core regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pbdve_pkg.sv
rtl/pbdve_chan_calc.sv
rtl/push_button_dim_value_encoder_core.sv
rtl/pbdve_checker.sv
dv/tb.sv
